/* hw/rtl/pss_pkg.sv */
// shared types and constants for the point sorter
package pss_pkg;

    // capacity of one point set
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // field widths
    localparam int X_W      = 12;
    localparam int Y_W      = 12;
    localparam int VALUE_W  = 16;
    localparam int TDATA_W  = 40;

    // one stored point
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [Y_W-1:0]     y;
        logic [X_W-1:0]     x;
    } entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_LOADI,
        ST_SCAN,
        ST_WRBACK,
        ST_OUT_RD,
        ST_OUT_CAP
    } state_t;

endpackage

/* hw/rtl/point_sort_by_value.sv */
// point sorter: collects a set of points, sorts by value descending, streams them out
//
// Points arrive one per transaction, one cycle each; the transaction with tlast closes
// the set. Up to 64 points are kept; further points of the set are discarded and every
// result of that set carries tuser = 1. All points sit in one single-port-read memory
// and a sequencer runs an exchange sort over it: for each position i it holds entry i
// in a register, reads entries i+1 .. n-1 one per cycle and swaps through the write
// port whenever a later value is larger, so on equal values the held entry stays.
// The sort runs at one memory read per cycle; output then reads each point, then
// captures it into the output register once that register is free, tlast on the
// final point. A new set is accepted as soon as the final result sits in the output
// register. No input is taken during sort or output.
module point_sort_by_value (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pss_pkg::TDATA_W-1:0] s_tdata,   // point_x, point_y, point_value
    input  logic                        s_tlast,   // set_last
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pss_pkg::TDATA_W-1:0] m_tdata,   // out_x, out_y, out_value
    output logic                        m_tlast,   // out_last
    output logic                        m_tuser    // dropped
);

    localparam int AW = pss_pkg::ADDR_W;
    localparam int CW = pss_pkg::CNT_W;

    // point memory
    pss_pkg::entry_t mem [pss_pkg::MAX_POINTS];
    pss_pkg::entry_t rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    pss_pkg::entry_t mem_wdata;
    logic [AW-1:0]   mem_raddr;

    // control state
    pss_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [AW-1:0]   jc_reg, jc_next;
    logic [AW-1:0]   k_reg, k_next;
    pss_pkg::entry_t cur_reg, cur_next;

    // output register
    logic            m_valid_reg, m_valid_next;
    pss_pkg::entry_t m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;
    logic            m_drop_reg, m_drop_next;

    // helpers
    logic            in_xfer;
    logic            room;
    logic [CW-1:0]   count_after;
    logic [CW-1:0]   i_ext;
    logic [CW-1:0]   k_ext;
    logic            out_last;
    logic            out_free;
    pss_pkg::entry_t in_entry;

    assign in_xfer     = s_tvalid && s_tready;
    assign room        = count_reg < CW'(pss_pkg::MAX_POINTS);
    assign count_after = count_reg + CW'(room);
    assign i_ext       = CW'(i_reg);
    assign k_ext       = CW'(k_reg);
    assign out_last    = (k_ext + CW'(1)) == count_reg;
    assign out_free    = !m_valid_reg || m_tready;

    assign in_entry.x     = s_tdata[pss_pkg::X_W-1:0];
    assign in_entry.y     = s_tdata[pss_pkg::X_W+pss_pkg::Y_W-1:pss_pkg::X_W];
    assign in_entry.value = s_tdata[pss_pkg::TDATA_W-1:pss_pkg::X_W+pss_pkg::Y_W];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.value, m_data_reg.y, m_data_reg.x};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_drop_reg;

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pss_pkg::ST_LOAD: begin
                if (in_xfer && s_tlast) begin
                    state_next = (count_after > CW'(1)) ? pss_pkg::ST_FETCH
                                                        : pss_pkg::ST_OUT_RD;
                end
            end
            pss_pkg::ST_FETCH:  state_next = pss_pkg::ST_LOADI;
            pss_pkg::ST_LOADI:  state_next = pss_pkg::ST_SCAN;
            pss_pkg::ST_SCAN: begin
                if (j_reg >= count_reg) begin
                    state_next = pss_pkg::ST_WRBACK;
                end
            end
            pss_pkg::ST_WRBACK: begin
                state_next = ((i_ext + CW'(2)) < count_reg) ? pss_pkg::ST_FETCH
                                                            : pss_pkg::ST_OUT_RD;
            end
            pss_pkg::ST_OUT_RD: begin
                if (out_free) begin
                    state_next = pss_pkg::ST_OUT_CAP;
                end
            end
            pss_pkg::ST_OUT_CAP: begin
                state_next = out_last ? pss_pkg::ST_LOAD : pss_pkg::ST_OUT_RD;
            end
            default: state_next = pss_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb begin
        s_tready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = cur_reg;
        mem_raddr    = '0;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        jc_next      = jc_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_drop_next  = m_drop_reg;

        // output register drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            pss_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (in_xfer) begin
                    if (room) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = in_entry;
                        count_next = count_after;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next = '0;
                        k_next = '0;
                    end
                end
            end
            // read entry i
            pss_pkg::ST_FETCH: begin
                mem_raddr = i_reg;
                j_next    = i_ext + CW'(1);
            end
            // hold entry i, start reading j = i+1
            pss_pkg::ST_LOADI: begin
                cur_next  = rdata_reg;
                mem_raddr = j_reg[AW-1:0];
                jc_next   = j_reg[AW-1:0];
                j_next    = j_reg + CW'(1);
            end
            // compare entry jc with held entry, swap when larger
            pss_pkg::ST_SCAN: begin
                if (rdata_reg.value > cur_reg.value) begin
                    mem_we    = 1'b1;
                    mem_waddr = jc_reg;
                    mem_wdata = cur_reg;
                    cur_next  = rdata_reg;
                end
                if (j_reg < count_reg) begin
                    mem_raddr = j_reg[AW-1:0];
                    jc_next   = j_reg[AW-1:0];
                    j_next    = j_reg + CW'(1);
                end
            end
            // place the winner at position i
            pss_pkg::ST_WRBACK: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = cur_reg;
                i_next    = i_reg + AW'(1);
                k_next    = '0;
            end
            pss_pkg::ST_OUT_RD: begin
                mem_raddr = k_reg;
            end
            // load the output register
            pss_pkg::ST_OUT_CAP: begin
                m_valid_next = 1'b1;
                m_data_next  = rdata_reg;
                m_last_next  = out_last;
                m_drop_next  = ovf_reg;
                k_next       = k_reg + AW'(1);
                if (out_last) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pss_pkg::ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and index registers
    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        jc_reg     <= jc_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_drop_reg <= m_drop_next;
    end

`ifndef ASSERT_OFF
    // fill count never passes capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(pss_pkg::MAX_POINTS))
        else $error("point count beyond capacity");

    // a point is only dropped once the memory is full
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> count_reg == CW'(pss_pkg::MAX_POINTS))
        else $error("overflow flagged with room left");

    // compared entry always lies inside the set
    a_scan_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pss_pkg::ST_SCAN) |-> (CW'(jc_reg) < count_reg))
        else $error("scan index outside the set");

    // a pending non-final result means the run is still being emitted
    a_run_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (state_reg == pss_pkg::ST_OUT_RD))
        else $error("run left before its final result");
`endif

endmodule
